@@ rtl/fpbg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fpbg_pkg;

   localparam int CNT_W  = 32;
   localparam int TIME_W = 64;
   localparam int PEAK_W = 63;

   localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
   localparam logic [TIME_W-1:0] THRESH_MIN = 64'd1;

   typedef enum logic [1:0] {
      ACT_OBSERVE  = 2'd0,
      ACT_EVALUATE = 2'd1,
      ACT_COMMIT   = 2'd2,
      ACT_RESET    = 2'd3
   } action_type;

   typedef struct packed {
      action_type        action;
      logic              grab_active;
      logic              focus_reliable;
      logic              focus_matches;
      logic [TIME_W-1:0] observe_time;
      logic              frame_fresh;
      logic [TIME_W-1:0] frame_time;
      logic              output_was_black;
   } req_word_type;

   typedef struct packed {
      logic              use_black;
      logic              waiting_safe;
      logic              entered_blackout;
      logic              exited_blackout;
      logic              focus_regained;
      logic [CNT_W-1:0]  entry_count;
      logic [CNT_W-1:0]  black_count;
      logic [CNT_W-1:0]  ambiguous_count;
      logic [PEAK_W-1:0] max_resume_wait;
      logic              last_black;
   } rsp_word_type;

   typedef struct packed {
      logic              focus_ok;
      logic              blackout_on;
      logic              awaiting_safe;
      logic              last_black;
      logic [TIME_W-1:0] threshold;
      logic [CNT_W-1:0]  entries;
      logic [CNT_W-1:0]  blacks;
      logic [CNT_W-1:0]  ambiguous;
      logic [PEAK_W-1:0] peak;
   } state_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + {{(CNT_W-1){1'b0}}, 1'b1};
   endfunction

endpackage

`default_nettype wire

@@ rtl/fpbg_chan_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface fpbg_chan_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

@@ rtl/fpbg_decide.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fpbg_decide
   import fpbg_pkg::*;
(
   input  wire logic         gate_en,
   input  wire req_word_type word,
   input  wire state_type    state_cur,
   output state_type         state_nxt,
   output rsp_word_type      result
);

   state_type         st;
   logic              f_black, f_wait, f_enter, f_exit, f_regain;
   logic              decide;
   logic [TIME_W-1:0] diff;
   logic [TIME_W-1:0] wait_t;

   always_comb begin
      st       = state_cur;
      f_black  = 1'b0;
      f_wait   = 1'b0;
      f_enter  = 1'b0;
      f_exit   = 1'b0;
      f_regain = 1'b0;
      diff     = '0;
      wait_t   = '0;
      decide   = gate_en && word.grab_active &&
                 (word.action == ACT_OBSERVE || word.action == ACT_EVALUATE);

      if (decide) begin
         // focus tracking shared by observe and evaluate
         if (!word.focus_reliable || !word.focus_matches) begin
            if (!word.focus_reliable) begin
               st.ambiguous = sat_inc(st.ambiguous);
            end
            if (!st.blackout_on) begin
               st.entries = sat_inc(st.entries);
               f_enter    = 1'b1;
            end
            st.focus_ok      = 1'b0;
            st.blackout_on   = 1'b1;
            st.awaiting_safe = 1'b1;
            st.threshold     = '0;
         end else if (!st.focus_ok) begin
            st.focus_ok = 1'b1;
            if (!st.blackout_on) begin
               st.entries = sat_inc(st.entries);
               f_enter    = 1'b1;
            end
            st.blackout_on   = 1'b1;
            st.awaiting_safe = 1'b1;
            st.threshold     = ($signed(word.observe_time) < $signed(THRESH_MIN)) ?
                               THRESH_MIN : word.observe_time;
            f_regain         = 1'b1;
         end

         if (word.action == ACT_OBSERVE) begin
            f_wait = st.awaiting_safe;
         end else if (!st.focus_ok) begin
            f_black = 1'b1;
            f_wait  = 1'b1;
         end else if (st.awaiting_safe) begin
            if (!word.frame_fresh ||
                $signed(word.frame_time) < $signed(st.threshold)) begin
               f_black = 1'b1;
               f_wait  = 1'b1;
            end else begin
               // negative wait counts as zero
               diff = word.observe_time - st.threshold;
               if (!($signed(word.observe_time) < $signed(st.threshold))) begin
                  wait_t = diff;
               end
               if (wait_t > {1'b0, st.peak}) begin
                  st.peak = wait_t[PEAK_W-1:0];
               end
               st.awaiting_safe = 1'b0;
               st.blackout_on   = 1'b0;
               f_exit           = 1'b1;
            end
         end
      end else begin
         unique case (word.action)
            ACT_OBSERVE, ACT_EVALUATE: begin
            end
            ACT_COMMIT: begin
               st.last_black = word.output_was_black;
               if (word.output_was_black) begin
                  st.blacks = sat_inc(st.blacks);
               end
            end
            ACT_RESET: begin
               st.focus_ok      = 1'b0;
               st.blackout_on   = 1'b0;
               st.awaiting_safe = gate_en;
               st.last_black    = 1'b0;
               st.threshold     = '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign state_nxt = st;

   always_comb begin
      result.use_black        = f_black;
      result.waiting_safe     = f_wait;
      result.entered_blackout = f_enter;
      result.exited_blackout  = f_exit;
      result.focus_regained   = f_regain;
      result.entry_count      = st.entries;
      result.black_count      = st.blacks;
      result.ambiguous_count  = st.ambiguous;
      result.max_resume_wait  = st.peak;
      result.last_black       = st.last_black;
   end

endmodule

`default_nettype wire

@@ rtl/focus_privacy_blanking_gate_core.sv @@
// an accepted request word goes through the input and output registers
// in turn; throughput: one word per cycle while the output moves on
// the input register takes a new word when empty or the output moves on
// reset (synchronous, active high) clears the gate enable, all policy state
// and the counters; a csr write clears them but awaiting_safe = new enable
`timescale 1ns / 1ps
`default_nettype none

module focus_privacy_blanking_gate_core
   import fpbg_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_we,
   input  wire logic          csr_wdata,
   fpbg_chan_if.sink          req_chan,
   fpbg_chan_if.source        rsp_chan
);

   logic         gate_en_ff, gate_en_in;
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff, in_word_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   state_type    state_ff, state_in;
   state_type    state_calc;
   rsp_word_type result_calc;
   logic         advance;
   logic         fire;
   logic         req_take;

   fpbg_decide u_decide (
      .gate_en   (gate_en_ff),
      .word      (in_word_ff),
      .state_cur (state_ff),
      .state_nxt (state_calc),
      .result    (result_calc)
   );

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_word_in   = in_word_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      state_in     = state_ff;
      gate_en_in   = gate_en_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
      if (req_take) begin
         in_word_in = req_chan.word;
      end
      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end
      if (fire) begin
         rsp_word_in = result_calc;
         state_in    = state_calc;
      end
      if (csr_we) begin
         gate_en_in             = csr_wdata;
         state_in               = '0;
         state_in.awaiting_safe = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_en_ff   <= 1'b0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         gate_en_ff   <= gate_en_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // word registers carry no reset
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.word  = rsp_word_ff;

`ifndef SYNTHESIS
   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (state_ff.entries == '0 && state_ff.blacks == '0 &&
                  state_ff.ambiguous == '0 && state_ff.peak == '0 &&
                  state_ff.awaiting_safe == gate_en_ff))
      else $error("csr write did not clear the gate state");

   a_focus_thresh: assert property (@(posedge clock) disable iff (reset)
      state_ff.focus_ok |-> ($signed(state_ff.threshold) > $signed(TIME_W'(0))))
      else $error("focus held with no safe-frame threshold armed");

   a_black_waits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_word_ff.use_black || rsp_word_ff.waiting_safe))
      else $error("black response without waiting flag");

   a_entries_grow: assert property (@(posedge clock) disable iff (reset)
      !csr_we |=> (state_ff.entries >= $past(state_ff.entries)))
      else $error("entry counter went backwards");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while both registers are held");
`endif

endmodule

`default_nettype wire
